// File: rtl/a85sd_pkg.sv
package a85sd_pkg;

  // Character codes the scanner looks for.
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  // Error codes carried on the result words.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_END_IN_RGN = 3'd1;
  localparam logic [2:0] ERR_TILDE     = 3'd2;
  localparam logic [2:0] ERR_Z_MID     = 3'd3;
  localparam logic [2:0] ERR_ILLEGAL   = 3'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One job handed from the scanner to the output sequencer: up to four bytes
  // taken most significant first, then optionally one status word.
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nb;
    logic        tail;
    logic [2:0]  err;
    logic        done;
  } a85_job_t;

  // Weight of the digit at a given place in a five-digit group.
  function automatic logic [31:0] pow85(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'd52200625;
      3'd1:    w = 32'd614125;
      3'd2:    w = 32'd7225;
      3'd3:    w = 32'd85;
      default: w = 32'd1;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/ascii85_stream_decoder_unit.sv
// Streaming ASCII85 decoder.
// Input channel (in_valid, in_stall, ch, end_of_input) takes one character
// word per cycle unless in_stall is high. Output channel (out_valid,
// out_stall, out_byte, has_byte, error_code, done_res, last) gives result
// words; last marks the final word caused by one character, and done_res
// the closing status word of a stream. The configuration channel (cfg_valid,
// cfg_ready, cfg_data) sets whether characters outside encoded regions are
// passed through; it is always ready. A scanner takes a character every
// cycle unless stalled and posts a job of up to five result words into a
// four-entry queue; the output sequencer drains that queue at one word per
// cycle, when the receiver does not stall, into a registered output stage.
// The first result of a character passes through the queue entry and then
// the registered output stage. Throughput is one character per cycle while
// each character gives at most one word; a group of five digits or a 'z'
// gives four words, so the output port's one word per cycle sets the rate
// during runs of 'z'. When the receiver stalls, the output word holds, the
// queue fills and then in_stall rises until space is free again.
// A synchronous reset empties the queue, drops any pending output, leaves
// the scanner outside a region and clears the pass-through setting.
module ascii85_stream_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic [2:0] error_code,
  output logic       done_res,
  output logic       last
);

  a85sd_pkg::a85_job_t push_job;
  a85sd_pkg::a85_job_t head;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;

  a85sd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .ch           (ch),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .push         (push),
    .job          (push_job)
  );

  a85sd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  a85sd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_byte   (has_byte),
    .error_code (error_code),
    .done_res   (done_res),
    .last       (last)
  );

endmodule

// File: rtl/a85sd_front.sv
module a85sd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          ch,
  input  logic                end_of_input,
  input  logic                q_full,
  output logic                push,
  output a85sd_pkg::a85_job_t job
);

  typedef enum logic [2:0] {
    MODE_OUT   = 3'd0,
    MODE_LT    = 3'd1,
    MODE_IN    = 3'd2,
    MODE_TILDE = 3'd3,
    MODE_FAIL  = 3'd4
  } mode_t;

  mode_t       mode, mode_next;
  logic [2:0]  dc, dc_next;
  logic [31:0] gv, gv_next;
  logic        preserve;
  logic        accept;
  logic        ignored;
  logic [6:0]  dig;
  logic [31:0] prod;
  logic [31:0] dig_sum;
  logic [31:0] close_sum;
  logic [2:0]  err_here;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  assign ignored = (ch == 8'h0A) || (ch == 8'h0D) || (ch == 8'h09) || (ch == 8'h20) ||
                   (ch == 8'h00) || (ch == 8'h0C) || (ch == 8'h08) ||
                   (ch == a85sd_pkg::CH_DEL);

  assign dig       = 7'(ch - a85sd_pkg::CH_BANG);
  assign prod      = {25'd0, dig} * a85sd_pkg::pow85(dc);
  assign dig_sum   = gv + prod;
  assign close_sum = gv + a85sd_pkg::pow85(dc - 3'd1);

  always_comb begin
    mode_next = mode;
    dc_next   = dc;
    gv_next   = gv;
    job       = '0;
    err_here  = a85sd_pkg::ERR_NONE;
    unique case (mode)
      MODE_LT: begin
        if (ch == a85sd_pkg::CH_TILDE) begin
          mode_next = MODE_IN;
          gv_next   = '0;
          dc_next   = '0;
        end else begin
          if (preserve) begin
            job.data = {a85sd_pkg::CH_LT, ch, 16'd0};
            job.nb   = 3'd2;
          end
          mode_next = MODE_OUT;
        end
      end
      MODE_IN: begin
        if (ch == a85sd_pkg::CH_TILDE) begin
          mode_next = MODE_TILDE;
        end else if (ch == a85sd_pkg::CH_Z) begin
          if (dc != 3'd0) begin
            mode_next = MODE_FAIL;
            dc_next   = a85sd_pkg::ERR_Z_MID;
            gv_next   = '0;
          end else begin
            job.nb = 3'd4;
          end
        end else if (ignored) begin
          mode_next = MODE_IN;
        end else if (ch < a85sd_pkg::CH_BANG || ch > a85sd_pkg::CH_U) begin
          mode_next = MODE_FAIL;
          dc_next   = a85sd_pkg::ERR_ILLEGAL;
          gv_next   = '0;
        end else if (dc == 3'd4) begin
          job.data = dig_sum;
          job.nb   = 3'd4;
          gv_next  = '0;
          dc_next  = '0;
        end else begin
          gv_next = dig_sum;
          dc_next = dc + 3'd1;
        end
      end
      MODE_TILDE: begin
        if (ch == a85sd_pkg::CH_GT) begin
          // A short group of n digits gives n-1 bytes.
          if (dc != 3'd0) begin
            job.data = close_sum;
            job.nb   = dc - 3'd1;
          end
          gv_next   = '0;
          dc_next   = '0;
          mode_next = MODE_OUT;
        end else begin
          mode_next = MODE_FAIL;
          dc_next   = a85sd_pkg::ERR_TILDE;
          gv_next   = '0;
        end
      end
      MODE_FAIL: begin
        mode_next = MODE_FAIL;
      end
      default: begin
        if (ch == a85sd_pkg::CH_LT) begin
          mode_next = MODE_LT;
        end else if (preserve) begin
          job.data = {ch, 24'd0};
          job.nb   = 3'd1;
        end
      end
    endcase

    if (mode != MODE_FAIL && mode_next == MODE_FAIL) begin
      err_here = dc_next;
    end

    if (end_of_input) begin
      // A '<' still held back at the end of the stream is released here.
      if (mode_next == MODE_LT && preserve) begin
        job.data = {a85sd_pkg::CH_LT, 24'd0};
        job.nb   = 3'd1;
      end
      job.tail = 1'b1;
      job.done = 1'b1;
      if (mode_next == MODE_IN || mode_next == MODE_TILDE) begin
        job.err = a85sd_pkg::ERR_END_IN_RGN;
      end else if (mode_next == MODE_FAIL) begin
        job.err = dc_next;
      end else begin
        job.err = a85sd_pkg::ERR_NONE;
      end
      mode_next = MODE_OUT;
      dc_next   = '0;
      gv_next   = '0;
    end else if (err_here != a85sd_pkg::ERR_NONE) begin
      job.tail = 1'b1;
      job.err  = err_here;
    end
  end

  assign push = accept && (job.nb != 3'd0 || job.tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_OUT;
      dc       <= '0;
      gv       <= '0;
      preserve <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        preserve <= cfg_data;
      end
      if (accept) begin
        mode <= mode_next;
        dc   <= dc_next;
        gv   <= gv_next;
      end
    end
  end

endmodule

// File: rtl/a85sd_queue.sv
module a85sd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  a85sd_pkg::a85_job_t push_job,
  output logic                full,
  input  logic                pop,
  output a85sd_pkg::a85_job_t head,
  output logic                empty
);

  a85sd_pkg::a85_job_t                 mem [a85sd_pkg::QUEUE_DEPTH];
  logic [a85sd_pkg::QPTR_W-1:0]        wr_ptr;
  logic [a85sd_pkg::QPTR_W-1:0]        rd_ptr;
  logic [a85sd_pkg::QCNT_W-1:0]        count;

  assign full  = (count == a85sd_pkg::QCNT_W'(a85sd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/a85sd_back.sv
module a85sd_back (
  input  logic                clk,
  input  logic                rst,
  input  a85sd_pkg::a85_job_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic [2:0]          error_code,
  output logic                done_res,
  output logic                last
);

  logic [2:0] pos;
  logic       advance;
  logic       emit;
  logic       is_byte;
  logic       final_word;
  logic [7:0] sel_byte;

  assign advance = !out_valid || !out_stall;
  assign emit    = advance && !empty;
  assign is_byte = (pos < head.nb);

  always_comb begin
    case (pos[1:0])
      2'd0:    sel_byte = head.data[31:24];
      2'd1:    sel_byte = head.data[23:16];
      2'd2:    sel_byte = head.data[15:8];
      default: sel_byte = head.data[7:0];
    endcase
  end

  assign final_word = is_byte ? ((pos + 3'd1 == head.nb) && !head.tail) : 1'b1;
  assign pop        = emit && final_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      out_valid <= !empty;
      if (emit) begin
        pos <= final_word ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= is_byte ? sel_byte : 8'd0;
      has_byte   <= is_byte;
      error_code <= is_byte ? a85sd_pkg::ERR_NONE : head.err;
      done_res   <= !is_byte && head.done;
      last       <= final_word;
    end
  end

endmodule

// File: rtl/a85sd_checker.sv
module a85sd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic [2:0] error_code,
  input logic       done_res,
  input logic       last
);

  // A stalled output word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(has_byte) &&
      $stable(error_code) && $stable(done_res) && $stable(last))
    else $error("output word changed while stalled");

  // Byte words never carry an error code.
  a_byte_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> error_code == a85sd_pkg::ERR_NONE)
    else $error("byte word carries an error code");

  // The closing status word of a stream is the last word of its character.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> last && !has_byte && out_byte == 8'd0)
    else $error("closing status word malformed");

  // A status word that does not close the stream reports a real error.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte && !done_res |-> last && error_code != a85sd_pkg::ERR_NONE)
    else $error("error word without an error code");

endmodule

bind ascii85_stream_decoder_unit a85sd_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .has_byte   (has_byte),
  .error_code (error_code),
  .done_res   (done_res),
  .last       (last)
);
